// ===== rtl/nps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler package
// Shared sizes, job and result records, ALU request and sequencer states.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);

  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int ID_W    = 5;
  localparam int TIME_W  = 21;
  localparam int SUM_W   = 25;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arr;
  } job_t;

  localparam int JOB_W       = $bits(job_t);
  localparam int IN_TDATA_W  = ((JOB_W + 7) / 8) * 8;
  localparam int OUT_BITS    = ID_W + 3 * TIME_W + 2 * SUM_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] ct;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic [SUM_W-1:0]  tsum;
    logic [SUM_W-1:0]  wsum;
    logic              drop;
    logic              last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_E,
    S_SCAN_B,
    S_CT,
    S_TAT,
    S_WT,
    S_TSUM,
    S_WSUM,
    S_EMIT
  } state_e;

endpackage

// ===== rtl/nps_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nps_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/nps_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared adder
// Add or subtract unit used for the completion, turnaround, waiting and sum updates of the schedule.
// ----------------------------------------------------------------------------
module nps_alu (
  input  nps_pkg::alu_req_t         req_i,
  output logic [nps_pkg::SUM_W-1:0] res_o
);
  import nps_pkg::*;

  always_comb begin
    if (req_i.sub) begin
      res_o = req_i.a - req_i.b;
    end else begin
      res_o = req_i.a + req_i.b;
    end
  end

endmodule

// ===== rtl/nps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Loads jobs, scans the job store for each pick and steps the shared adder.
// ----------------------------------------------------------------------------
module nps_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  nps_pkg::job_t             in_job_i,
  input  logic                      in_last_i,
  output logic                      ram_we_o,
  output logic [nps_pkg::IDX_W-1:0] ram_waddr_o,
  output nps_pkg::job_t             ram_wdata_o,
  output logic [nps_pkg::IDX_W-1:0] ram_raddr_o,
  input  nps_pkg::job_t             ram_rdata_i,
  output nps_pkg::alu_req_t         alu_req_o,
  input  logic [nps_pkg::SUM_W-1:0] alu_res_i,
  output nps_pkg::result_t          emit_o,
  input  logic                      emit_ok_i
);
  import nps_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    k_q, k_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                pend_q, pend_d;
  logic                ovf_q, ovf_d;
  logic [MAX_JOBS-1:0] done_q, done_d;
  logic [TIME_W-1:0]   time_q, time_d;
  logic [SUM_W-1:0]    tsum_q, tsum_d;
  logic [SUM_W-1:0]    wsum_q, wsum_d;
  logic                efound_q, efound_d;
  logic                bfound_q, bfound_d;

  logic [IDX_W-1:0]    pidx_q, pidx_d;
  logic [ARR_W-1:0]    earl_q, earl_d;
  job_t                best_q, best_d;
  logic [IDX_W-1:0]    bidx_q, bidx_d;
  logic [TIME_W-1:0]   tat_q, tat_d;
  logic [TIME_W-1:0]   wt_q, wt_d;

  logic                is_last;
  logic [31:0]         id_full;

  assign is_last = (k_q == cnt_q - CNT_W'(1));
  assign id_full = 32'(bidx_q) + 32'd1;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    idx_d    = idx_q;
    pend_d   = pend_q;
    ovf_d    = ovf_q;
    done_d   = done_q;
    time_d   = time_q;
    tsum_d   = tsum_q;
    wsum_d   = wsum_q;
    efound_d = efound_q;
    bfound_d = bfound_q;
    pidx_d   = pidx_q;
    earl_d   = earl_q;
    best_d   = best_q;
    bidx_d   = bidx_q;
    tat_d    = tat_q;
    wt_d     = wt_q;

    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q[IDX_W-1:0];
    ram_wdata_o = in_job_i;
    ram_raddr_o = idx_q[IDX_W-1:0];
    alu_req_o   = '0;

    emit_o        = '0;
    emit_o.job_id = id_full[ID_W-1:0];
    emit_o.ct     = time_q;
    emit_o.tat    = tat_q;
    emit_o.wt     = wt_q;
    emit_o.tsum   = is_last ? tsum_q : '0;
    emit_o.wsum   = is_last ? wsum_q : '0;
    emit_o.drop   = ovf_q;
    emit_o.last   = is_last;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < CNT_W'(MAX_JOBS)) begin
            ram_we_o = 1'b1;
            cnt_d    = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            state_d  = S_SCAN_E;
            idx_d    = '0;
            pend_d   = 1'b0;
            efound_d = 1'b0;
            k_d      = '0;
          end
        end
      end
      S_SCAN_E: begin
        if (idx_q < cnt_q) begin
          pend_d = 1'b1;
          pidx_d = idx_q[IDX_W-1:0];
          idx_d  = idx_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && !done_q[pidx_q]) begin
          if (!efound_q || (ram_rdata_i.arr < earl_q)) begin
            earl_d   = ram_rdata_i.arr;
            efound_d = 1'b1;
          end
        end
        if ((idx_q >= cnt_q) && !pend_q) begin
          if (TIME_W'(earl_q) > time_q) begin
            time_d = TIME_W'(earl_q);
          end
          idx_d    = '0;
          bfound_d = 1'b0;
          state_d  = S_SCAN_B;
        end
      end
      S_SCAN_B: begin
        if (idx_q < cnt_q) begin
          pend_d = 1'b1;
          pidx_d = idx_q[IDX_W-1:0];
          idx_d  = idx_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && !done_q[pidx_q] && (TIME_W'(ram_rdata_i.arr) <= time_q)) begin
          if (!bfound_q || (ram_rdata_i.prio < best_q.prio) ||
              ((ram_rdata_i.prio == best_q.prio) && (ram_rdata_i.arr < best_q.arr))) begin
            best_d   = ram_rdata_i;
            bidx_d   = pidx_q;
            bfound_d = 1'b1;
          end
        end
        if ((idx_q >= cnt_q) && !pend_q) begin
          state_d = S_CT;
        end
      end
      S_CT: begin
        alu_req_o.a   = SUM_W'(time_q);
        alu_req_o.b   = SUM_W'(best_q.burst);
        alu_req_o.sub = 1'b0;
        time_d        = alu_res_i[TIME_W-1:0];
        state_d       = S_TAT;
      end
      S_TAT: begin
        alu_req_o.a   = SUM_W'(time_q);
        alu_req_o.b   = SUM_W'(best_q.arr);
        alu_req_o.sub = 1'b1;
        tat_d         = alu_res_i[TIME_W-1:0];
        state_d       = S_WT;
      end
      S_WT: begin
        alu_req_o.a   = SUM_W'(tat_q);
        alu_req_o.b   = SUM_W'(best_q.burst);
        alu_req_o.sub = 1'b1;
        wt_d          = alu_res_i[TIME_W-1:0];
        state_d       = S_TSUM;
      end
      S_TSUM: begin
        alu_req_o.a   = tsum_q;
        alu_req_o.b   = SUM_W'(tat_q);
        alu_req_o.sub = 1'b0;
        tsum_d        = alu_res_i;
        state_d       = S_WSUM;
      end
      S_WSUM: begin
        alu_req_o.a   = wsum_q;
        alu_req_o.b   = SUM_W'(wt_q);
        alu_req_o.sub = 1'b0;
        wsum_d        = alu_res_i;
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        emit_o.valid = 1'b1;
        if (emit_ok_i) begin
          if (is_last) begin
            done_d  = '0;
            cnt_d   = '0;
            ovf_d   = 1'b0;
            time_d  = '0;
            tsum_d  = '0;
            wsum_d  = '0;
            k_d     = '0;
            state_d = S_IDLE;
          end else begin
            done_d[bidx_q] = 1'b1;
            k_d      = k_q + CNT_W'(1);
            idx_d    = '0;
            pend_d   = 1'b0;
            efound_d = 1'b0;
            state_d  = S_SCAN_E;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      k_q      <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      ovf_q    <= 1'b0;
      done_q   <= '0;
      time_q   <= '0;
      tsum_q   <= '0;
      wsum_q   <= '0;
      efound_q <= 1'b0;
      bfound_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      k_q      <= k_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      ovf_q    <= ovf_d;
      done_q   <= done_d;
      time_q   <= time_d;
      tsum_q   <= tsum_d;
      wsum_q   <= wsum_d;
      efound_q <= efound_d;
      bfound_q <= bfound_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    earl_q <= earl_d;
    best_q <= best_d;
    bidx_q <= bidx_d;
    tat_q  <= tat_d;
    wt_q   <= wt_d;
  end

endmodule

// ===== rtl/nonpreemptive_priority_scheduler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Non-preemptive priority scheduler
// Collects a batch of jobs and returns one timing record per job in run order.
// ----------------------------------------------------------------------------
// Jobs enter on the slave stream, one beat per job, and are numbered from 1 in
// load order. A beat with tlast set closes the batch and starts the schedule;
// jobs beyond the store capacity are dropped and flagged in tuser of every
// result. Loading accepts one beat per cycle.
// Each result beat carries the job id, completion, turnaround and waiting
// times; the beat with tlast set is the final one and also carries the totals.
// Every pick makes two passes over the n stored jobs through the single read
// port of the job store (earliest pending arrival, then best ready job),
// followed by the completion, turnaround, waiting and total updates on the
// shared adder and a hand-off step that passes the result to the output register.
// The slave side is not ready while a batch is being scheduled.
// A stalled receiver holds the output register; the sequencer waits at its
// hand-off step until the register drains. After the final result the next
// batch can be loaded at once, with time starting again at zero.
// Reset clears the batch state and the output valid flag; no job is held.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // arrival_time, burst_length, priority_level
  input  logic [nps_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // job_id, completion_time, turnaround_time, waiting_time, total_turnaround,
  // total_waiting, zero padding
  output logic [nps_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // dropped_jobs
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);
  import nps_pkg::*;

  job_t             in_job;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  job_t             ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [JOB_W-1:0] ram_rdata;
  alu_req_t         alu_req;
  logic [SUM_W-1:0] alu_res;
  result_t          emit;
  logic             emit_ok;
  logic             out_valid_q;
  result_t          out_q;

  assign in_job  = job_t'(s_axis_tdata_i[JOB_W-1:0]);
  assign emit_ok = !out_valid_q || m_axis_tready_i;

  nps_ram #(
    .WIDTH (JOB_W),
    .DEPTH (MAX_JOBS),
    .AW    (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  nps_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  nps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_job_i    (in_job),
    .in_last_i   (s_axis_tlast_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (job_t'(ram_rdata)),
    .alu_req_o   (alu_req),
    .alu_res_i   (alu_res),
    .emit_o      (emit),
    .emit_ok_i   (emit_ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid && emit_ok) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid && emit_ok) begin
      out_q <= emit;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - OUT_BITS)'(0), out_q.wsum, out_q.tsum, out_q.wt,
                            out_q.tat, out_q.ct, out_q.job_id};
  assign m_axis_tuser_o  = out_q.drop;
  assign m_axis_tlast_o  = out_q.last;

endmodule

// ===== sim/nps_schedule_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler result checker
// Mirrors job loading on the slave stream and predicts the run order and
// timing of every closed batch. Each master beat is compared field by field
// with the oldest predicted record. The mismatch count and the number of
// records still outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------
module nps_schedule_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  input  logic [nps_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  input  logic [nps_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                            m_axis_tuser_i,
  input  logic                            m_axis_tlast_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import nps_pkg::*;

  localparam int CT_LSB   = ID_W;
  localparam int TAT_LSB  = CT_LSB + TIME_W;
  localparam int WT_LSB   = TAT_LSB + TIME_W;
  localparam int TSUM_LSB = WT_LSB + TIME_W;
  localparam int WSUM_LSB = TSUM_LSB + SUM_W;

  typedef struct {
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] ct;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic [SUM_W-1:0]  tsum;
    logic [SUM_W-1:0]  wsum;
    logic              drop;
    logic              last;
  } run_rec_t;

  logic [ARR_W-1:0]   arr_mem   [MAX_JOBS];
  logic [BURST_W-1:0] burst_mem [MAX_JOBS];
  logic [PRIO_W-1:0]  prio_mem  [MAX_JOBS];
  int                 held_jobs;
  logic               overflow;
  run_rec_t           expected_runs [$];
  int                 mismatch_tally = 0;
  int                 result_beats;

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    mismatch_tally++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result beat %0d: %s is 0x%0h, expected 0x%0h",
                                result_beats, name, got, want));
    end
  endtask

  function automatic bit runs_before(input int a, input int b);
    if (prio_mem[a] != prio_mem[b]) return prio_mem[a] < prio_mem[b];
    if (arr_mem[a] != arr_mem[b]) return arr_mem[a] < arr_mem[b];
    return a < b;
  endfunction

  task automatic schedule_batch();
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] earliest;
    logic [TIME_W-1:0] ct;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic [SUM_W-1:0]  tsum;
    logic [SUM_W-1:0]  wsum;
    bit                finished [MAX_JOBS];
    bit                any;
    int                best;
    run_rec_t          rec;
    now  = '0;
    tsum = '0;
    wsum = '0;
    foreach (finished[i]) finished[i] = 1'b0;
    for (int k = 0; k < held_jobs; k++) begin
      any = 1'b0;
      earliest = '0;
      for (int i = 0; i < held_jobs; i++) begin
        if (!finished[i] && (!any || TIME_W'(arr_mem[i]) < earliest)) begin
          earliest = TIME_W'(arr_mem[i]);
          any = 1'b1;
        end
      end
      if (earliest > now) now = earliest;
      best = -1;
      for (int i = 0; i < held_jobs; i++) begin
        if (!finished[i] && TIME_W'(arr_mem[i]) <= now &&
            (best < 0 || runs_before(i, best))) begin
          best = i;
        end
      end
      ct  = now + TIME_W'(burst_mem[best]);
      tat = ct - TIME_W'(arr_mem[best]);
      wt  = tat - TIME_W'(burst_mem[best]);
      now = ct;
      finished[best] = 1'b1;
      tsum = tsum + SUM_W'(tat);
      wsum = wsum + SUM_W'(wt);
      rec.job_id = ID_W'(best + 1);
      rec.ct     = ct;
      rec.tat    = tat;
      rec.wt     = wt;
      rec.drop   = overflow;
      rec.last   = (k == held_jobs - 1);
      rec.tsum   = rec.last ? tsum : '0;
      rec.wsum   = rec.last ? wsum : '0;
      expected_runs.push_back(rec);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    run_rec_t want;
    if (!rst_ni) begin
      held_jobs = 0;
      overflow = 1'b0;
      result_beats = 0;
      expected_runs.delete();
      fail_count_o <= mismatch_tally;
      pending_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (held_jobs < MAX_JOBS) begin
          arr_mem[held_jobs]   = s_axis_tdata_i[ARR_W-1:0];
          burst_mem[held_jobs] = s_axis_tdata_i[ARR_W +: BURST_W];
          prio_mem[held_jobs]  = s_axis_tdata_i[ARR_W+BURST_W +: PRIO_W];
          held_jobs++;
        end else begin
          overflow = 1'b1;
        end
        if (s_axis_tlast_i) begin
          schedule_batch();
          held_jobs = 0;
          overflow = 1'b0;
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_runs.size() == 0) begin
          report_mismatch($sformatf("result beat %0d arrived with no job outstanding",
                                    result_beats));
        end else begin
          want = expected_runs.pop_front();
          compare_field("job_id", 32'(m_axis_tdata_i[ID_W-1:0]), 32'(want.job_id));
          compare_field("completion_time", 32'(m_axis_tdata_i[CT_LSB +: TIME_W]),
                        32'(want.ct));
          compare_field("turnaround_time", 32'(m_axis_tdata_i[TAT_LSB +: TIME_W]),
                        32'(want.tat));
          compare_field("waiting_time", 32'(m_axis_tdata_i[WT_LSB +: TIME_W]),
                        32'(want.wt));
          compare_field("total_turnaround", 32'(m_axis_tdata_i[TSUM_LSB +: SUM_W]),
                        32'(want.tsum));
          compare_field("total_waiting", 32'(m_axis_tdata_i[WSUM_LSB +: SUM_W]),
                        32'(want.wsum));
          compare_field("padding", 32'(m_axis_tdata_i[OUT_TDATA_W-1:OUT_BITS]), '0);
          compare_field("dropped_jobs", 32'(m_axis_tuser_i), 32'(want.drop));
          compare_field("last_result", 32'(m_axis_tlast_i), 32'(want.last));
        end
        result_beats++;
      end
      fail_count_o <= mismatch_tally;
      pending_o <= expected_runs.size();
    end
  end

endmodule

// ===== sim/nonpreemptive_priority_scheduler_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Non-preemptive priority scheduler testbench
// Sends directed and random job batches with random gaps on both streams,
// including an overflowing batch, a long receiver hold-off and full drains.
// The checker predicts every result beat; this top only drives and judges.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_unit_tb;
  import nps_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 120;
  localparam int RANDOM_ITEMS = 360;

  logic                   clk;
  logic                   rst_n;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  int                     fail_count;
  int                     pending;
  int                     items_sent = 0;
  int                     results_taken = 0;
  int                     calm_left = 0;
  bit                     held_off = 1'b0;

  nonpreemptive_priority_scheduler_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  nps_schedule_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_job(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                          input logic [PRIO_W-1:0] prio, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {prio, burst, arr};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random_batch();
    int r;
    int n;
    int arr_span;
    int prio_span;
    logic [BURST_W-1:0] burst;
    r = $urandom_range(0, 99);
    if (r < 8) n = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
    else if (r < 22) n = $urandom_range(1, 3);
    else if (r < 30) n = MAX_JOBS;
    else n = $urandom_range(4, MAX_JOBS - 1);
    case ($urandom_range(0, 2))
      0: arr_span = 20;
      1: arr_span = 2000;
      default: arr_span = 65535;
    endcase
    prio_span = $urandom_range(0, 1) ? 3 : 255;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) burst = BURST_W'($urandom_range(0, 65535));
      else burst = BURST_W'($urandom_range(0, 12));
      send_job(ARR_W'($urandom_range(0, arr_span)), burst,
               PRIO_W'($urandom_range(0, prio_span)), i == n - 1);
    end
  endtask

  initial begin
    int gap;
    m_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held_off && results_taken >= 40) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_taken++;
    end
  end

  initial begin
    int directed_items;
    int batch_no;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    rst_n    <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_job('0, '0, '0, 1'b1);
    send_job('1, '1, '1, 1'b1);
    send_job(16'd0, 16'd10, 8'd9, 1'b0);
    send_job(16'd5, 16'd4, 8'd2, 1'b0);
    send_job(16'd5, 16'd3, 8'd2, 1'b0);
    send_job(16'd3, 16'd2, 8'd2, 1'b0);
    send_job(16'd2, 16'd1, 8'd1, 1'b0);
    send_job(16'd500, 16'd1, 8'd0, 1'b1);
    for (int i = 0; i <= MAX_JOBS; i++) begin
      send_job(ARR_W'($urandom_range(0, 65535)), BURST_W'($urandom_range(0, 65535)),
               PRIO_W'($urandom_range(0, 255)), i == MAX_JOBS);
    end
    wait_for_drain();
    directed_items = items_sent;

    batch_no = 0;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      send_random_batch();
      batch_no++;
      if (batch_no == 6) wait_for_drain();
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
